// ===== design/mspts_pkg.sv =====
// ---------------------------------------------------------------------------
// mspts_pkg: shared types for the periodic tick scheduler
// Transfer payloads, mode codes and the per-slot control bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package mspts_pkg;

   localparam int unsigned SLOT_W   = 3;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned MASK_W   = 8;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_REG  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [SLOT_W-1:0]     slot;
      logic [PERIOD_W-1:0]   period;
      logic                  enable;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0]     fire_mask;
      logic [MASK_W-1:0]     enabled_mask;
      logic                  running;
      logic [COUNT_W-1:0]    now;
   } rsp_type;

   // control bundle from the top level to each slot
   typedef struct packed {
      logic                  commit;
      logic                  tick_run;
      logic [COUNT_W-1:0]    now;
      logic [COUNT_W-1:0]    now_next;
      logic [PERIOD_W-1:0]   period;
      logic                  enable;
   } slot_ctrl_type;

endpackage

`default_nettype wire

// ===== design/multi_slot_periodic_tick_scheduler.sv =====
// A request transfer is captured in the input register, which feeds the result
// register; one request per cycle is sustained while no result is stalled.
// Throughput is set by the single result register: it drains while a new
// item is computed, so only a stalled result holds up the request side.
// Reset (synchronous, active high) clears the count, all slot enables and
// both pipeline valids.
// ---------------------------------------------------------------------------
// multi_slot_periodic_tick_scheduler: periodic slot timer
// Millisecond counter with up to eight periodic slots; one result per item.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_slot_periodic_tick_scheduler #(
   parameter int unsigned SLOTS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire mspts_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output mspts_pkg::rsp_type      rsp_data
);

   logic                           in_valid_ff;
   logic                           in_valid_in;
   mspts_pkg::req_type             in_req_ff;
   mspts_pkg::req_type             in_req_in;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   mspts_pkg::rsp_type             out_rsp_ff;
   mspts_pkg::rsp_type             out_rsp_in;
   logic [mspts_pkg::COUNT_W-1:0]  count_ff;
   logic [mspts_pkg::COUNT_W-1:0]  count_in;

   logic                           advance;
   logic                           take;
   logic                           accept;
   logic                           running_now;
   logic                           is_tick;
   mspts_pkg::slot_ctrl_type       ctrl;
   logic [SLOTS-1:0]               sel_vec;
   logic [SLOTS-1:0]               fire_vec;
   logic [SLOTS-1:0]               en_cur_vec;
   logic [SLOTS-1:0]               en_next_vec;
   logic [mspts_pkg::MASK_W-1:0]   fire_mask;
   logic [mspts_pkg::MASK_W-1:0]   en_mask;

   // handshake: result register drains or is empty
   assign advance   = !out_valid_ff || !rsp_stall;
   assign take      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign is_tick     = (in_req_ff.mode == mspts_pkg::MODE_TICK);
   assign running_now = |en_cur_vec;

   always_comb begin
      count_in = count_ff;
      if (is_tick && running_now) begin
         count_in = count_ff + mspts_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      ctrl.commit   = take;
      ctrl.tick_run = is_tick && running_now;
      ctrl.now      = count_ff;
      ctrl.now_next = count_in;
      ctrl.period   = in_req_ff.period;
      ctrl.enable   = in_req_ff.enable;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      assign sel_vec[i] = (in_req_ff.mode == mspts_pkg::MODE_REG)
                          && (in_req_ff.slot == mspts_pkg::SLOT_W'(i));

      mspts_slot u_slot (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sel     (sel_vec[i]),
         .fire    (fire_vec[i]),
         .en_next (en_next_vec[i])
      );
   end

   // current enables: an unselected slot keeps its bit
   always_comb begin
      en_cur_vec = '0;
      for (int i = 0; i < SLOTS; i++) begin
         en_cur_vec[i] = g_slot_en(i);
      end
   end

   function automatic logic g_slot_en(input int idx);
      g_slot_en = sel_vec[idx] ? 1'b0 : en_next_vec[idx];
   endfunction

   always_comb begin
      fire_mask = '0;
      en_mask   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         fire_mask[i] = fire_vec[i];
         en_mask[i]   = en_next_vec[i];
      end
   end

   always_comb begin
      in_req_in = accept ? req_data : in_req_ff;

      in_valid_in = in_valid_ff;
      priority if (accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end

      out_rsp_in              = out_rsp_ff;
      out_valid_in            = out_valid_ff;
      if (take) begin
         out_rsp_in.fire_mask    = fire_mask;
         out_rsp_in.enabled_mask = en_mask;
         out_rsp_in.running      = |en_mask;
         out_rsp_in.now          = count_in;
         out_valid_in            = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (take) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

`default_nettype wire

// ===== design/mspts_slot.sv =====
// ---------------------------------------------------------------------------
// mspts_slot: one periodic slot
// Holds period, next-fire time and enable; reports a fire on a matching tick.
// ---------------------------------------------------------------------------
`default_nettype none

module mspts_slot (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mspts_pkg::slot_ctrl_type ctrl,
   input  wire logic                   sel,
   output logic                        fire,
   output logic                        en_next
);

   logic [mspts_pkg::PERIOD_W-1:0] period_ff;
   logic [mspts_pkg::PERIOD_W-1:0] period_in;
   logic [mspts_pkg::COUNT_W-1:0]  next_fire_ff;
   logic [mspts_pkg::COUNT_W-1:0]  next_fire_in;
   logic                           en_ff;
   logic                           en_in;

   assign fire    = ctrl.tick_run && en_ff && (next_fire_ff == ctrl.now_next);
   assign en_next = sel ? ctrl.enable : en_ff;

   always_comb begin
      period_in    = period_ff;
      next_fire_in = next_fire_ff;
      en_in        = en_ff;
      if (ctrl.commit) begin
         priority if (sel) begin
            period_in    = ctrl.period;
            next_fire_in = ctrl.now + ctrl.period;
            en_in        = ctrl.enable;
         end else if (fire) begin
            next_fire_in = next_fire_ff + period_ff;
         end
      end
   end

   // period and next-fire are only read once the slot has been written
   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      next_fire_ff <= next_fire_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else begin
         en_ff <= en_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mspts_checker.sv =====
// ---------------------------------------------------------------------------
// mspts_checker: port-level checks for the tick scheduler
// Watches both transfer channels and the consistency of each result.
// ---------------------------------------------------------------------------
`default_nettype none

module mspts_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire mspts_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire mspts_pkg::rsp_type rsp_data
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // running flag agrees with the enable mask
   a_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.running == (rsp_data.enabled_mask != '0)))
      else $error("running flag inconsistent with enabled mask");

   // only enabled slots fire
   a_fire_en: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.fire_mask & ~rsp_data.enabled_mask) == '0))
      else $error("disabled slot fired");

   // request side only backs up behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no pending result");

endmodule

bind multi_slot_periodic_tick_scheduler mspts_checker u_mspts_checker (.*);

`default_nettype wire
